### design/local_maxima_3x3_detector_core_defines.svh
`ifndef LOCAL_MAXIMA_3X3_DETECTOR_CORE_DEFINES_SVH
`define LOCAL_MAXIMA_3X3_DETECTOR_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define LM3_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define LM3_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// holds while reset is applied
`define LM3_ASSERT_RESET(name, cons, msg) \
    name: assert property (@(posedge clk) !rst_n |-> (cons)) \
        else $error(msg);

`endif

### design/lm3_pkg.sv
`default_nettype none

package lm3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W      = 8;
    localparam int CFG_W      = 11;
    localparam int CFG_ADDR_W = 2;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 10;

    localparam int ADDR_W   = $clog2(MAX_WIDTH);
    localparam int ROWCNT_W = $clog2(MAX_HEIGHT + 1);
    localparam int CMP_A    = (ADDR_W + 1 > CFG_W) ? ADDR_W + 1 : CFG_W;
    localparam int CMP_W    = (ROWCNT_W > CMP_A) ? ROWCNT_W : CMP_A;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = FIFO_PTR_W + 1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = CFG_ADDR_W'(1);

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } column_t;

    // index 0 = left, 1 = centre, 2 = right
    typedef column_t [2:0] window_t;

    function automatic logic judge(window_t w);
        logic smaller;
        logic greater;
        pix_t centre;
        smaller = 1'b0;
        greater = 1'b0;
        centre  = w[1].mid;
        for (int k = 0; k < 3; k++)
        begin
            if (w[k].top > centre) greater = 1'b1;
            if (w[k].top < centre) smaller = 1'b1;
            if (w[k].mid > centre) greater = 1'b1;
            if (w[k].mid < centre) smaller = 1'b1;
            if (w[k].bot > centre) greater = 1'b1;
            if (w[k].bot < centre) smaller = 1'b1;
        end
        return smaller && !greater;
    endfunction

endpackage

`default_nettype wire

### design/lm3_if.sv
`default_nettype none

interface lm3_in_if;
    import lm3_pkg::*;
    logic valid;
    logic ready;
    logic op;
    logic [PIX_W-1:0] pixel;
    modport source (output valid, output op, output pixel, input ready);
    modport sink (input valid, input op, input pixel, output ready);
endinterface

interface lm3_out_if;
    import lm3_pkg::*;
    logic valid;
    logic ready;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic is_max;
    logic last;
    modport source (output valid, output col, output row, output is_max, output last,
                    input ready);
    modport sink (input valid, input col, input row, input is_max, input last,
                  output ready);
endinterface

interface lm3_cfg_if;
    import lm3_pkg::*;
    logic valid;
    logic ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_W-1:0] data;
    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

### design/local_maxima_3x3_detector_core.sv
// 3x3 local-maximum detector for an 8-bit grayscale frame in raster order.
// pix_in carries one item per handshake: op selects a pixel or a drain tick.
// res_out gives col, row, is_max and last for each judged centre pixel.
// cfg writes frame_width (addr 0) and frame_height (addr 1); always ready.
// the first row gives no result; after it, a row's first pixel gives none,
// later pixels one, the row end two; after the frame, each drain item gives
// one result of the last row; results are registered in stage 1, then queued.
// throughput: one item per cycle while pix_in is ready; a pixel reads both
// 1024 x 8 line stores at its column and writes the older one back in the next cycle.
// a drain resumed after pixels rewrote the stores waits while FIX_READ and
// FIX_LOAD reload the previous column; otherwise drains run one per cycle.
// results pass through a four-entry queue, so pix_in stays ready while a
// result waits; ready drops when the queue would overflow or a drain reloads.
// reset clears counters, window and queue and restores 640 x 480; the line
// stores are not cleared and need no clearing pass.
`default_nettype none

module local_maxima_3x3_detector_core (
    input wire        clk,
    input wire        rst_n,
    lm3_cfg_if.sink   cfg,
    lm3_in_if.sink    pix_in,
    lm3_out_if.source res_out
);
    import lm3_pkg::*;

    typedef struct packed {
        logic              drain;
        logic              emit;
        logic              single;
        logic              first;
        logic              row_end;
        logic [ADDR_W-1:0] addr;
        logic [ROW_W-1:0]  row_out;
        pix_t              pixel;
    } stage_t;

    typedef struct packed {
        logic [COL_W-1:0] col0;
        logic [ROW_W-1:0] row;
        logic             max0;
        logic             max1;
        logic             two;
    } group_t;

    typedef enum logic [2:0] {
        FIX_IDLE = 3'b001,
        FIX_READ = 3'b010,
        FIX_LOAD = 3'b100
    } fix_state_t;

    // configuration
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.addr)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg.data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    logic [CMP_W-1:0] eff_w;
    logic [CMP_W-1:0] eff_h;
    logic [CMP_W-1:0] w_last;

    always_comb
    begin
        if (CMP_W'(frame_width_reg) < CMP_W'(2))
            eff_w = CMP_W'(2);
        else if (CMP_W'(frame_width_reg) > CMP_W'(MAX_WIDTH))
            eff_w = CMP_W'(MAX_WIDTH);
        else
            eff_w = CMP_W'(frame_width_reg);
        if (CMP_W'(frame_height_reg) < CMP_W'(1))
            eff_h = CMP_W'(1);
        else if (CMP_W'(frame_height_reg) > CMP_W'(MAX_HEIGHT))
            eff_h = CMP_W'(MAX_HEIGHT);
        else
            eff_h = CMP_W'(frame_height_reg);
        w_last = eff_w - CMP_W'(1);
    end

    // position counters
    logic [ADDR_W-1:0]   in_col_reg;
    logic [ROWCNT_W-1:0] in_row_reg;
    logic [ADDR_W-1:0]   out_col_reg;

    logic pix_live;
    logic drain_live;
    logic row_end;
    logic drain_end;
    logic row_is_one;
    logic in_acc;

    assign row_is_one = (in_row_reg == ROWCNT_W'(1));
    assign pix_live   = (pix_in.op == OP_PIXEL) && (CMP_W'(in_row_reg) < eff_h);
    assign drain_live = (pix_in.op == OP_DRAIN) && (in_row_reg != '0)
                        && (CMP_W'(in_row_reg) >= eff_h);
    assign row_end    = (CMP_W'(in_col_reg) >= w_last);
    assign drain_end  = (CMP_W'(out_col_reg) >= w_last);
    assign in_acc     = pix_in.valid && pix_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
        end
        else if (in_acc && pix_live)
        begin
            if (row_end)
            begin
                in_col_reg <= '0;
                in_row_reg <= in_row_reg + ROWCNT_W'(1);
            end
            else
            begin
                in_col_reg <= in_col_reg + ADDR_W'(1);
            end
        end
        else if (in_acc && drain_live)
        begin
            if (drain_end)
            begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
            end
            else
            begin
                out_col_reg <= out_col_reg + ADDR_W'(1);
            end
        end
    end

    // previous-column reload for drains
    fix_state_t fix_state_reg;
    fix_state_t fix_state_next;
    logic       prev_ok_reg;
    column_t    prev_col_reg;
    logic       s1_valid_reg;
    stage_t     s1_reg;
    logic       need_fix;

    assign need_fix = pix_in.valid && drain_live && (out_col_reg != '0) && !prev_ok_reg
                      && !(s1_valid_reg && s1_reg.drain) && (fix_state_reg != FIX_LOAD);

    always_comb
    begin
        fix_state_next = fix_state_reg;
        unique case (fix_state_reg)
            FIX_IDLE: if (need_fix && !s1_valid_reg) fix_state_next = FIX_READ;
            FIX_READ: fix_state_next = FIX_LOAD;
            FIX_LOAD: fix_state_next = FIX_IDLE;
            default:  fix_state_next = FIX_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fix_state_reg <= FIX_IDLE;
        else
            fix_state_reg <= fix_state_next;
    end

    // line stores
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic              newer_we;
    logic              older_we;
    pix_t              newer_mem [MAX_WIDTH];
    pix_t              older_mem [MAX_WIDTH];
    pix_t              newer_rd_a_reg;
    pix_t              newer_rd_b_reg;
    pix_t              older_rd_a_reg;
    pix_t              older_rd_b_reg;
    logic              fwd_a_reg;
    logic              fwd_b_reg;
    pix_t              fwd_data_reg;

    always_comb
    begin
        addr_a = in_col_reg;
        addr_b = in_col_reg;
        if (fix_state_reg == FIX_READ)
        begin
            addr_a = out_col_reg - ADDR_W'(1);
        end
        else if (pix_in.op == OP_DRAIN)
        begin
            addr_a = out_col_reg;
            addr_b = drain_end ? out_col_reg : out_col_reg + ADDR_W'(1);
        end
    end

    assign newer_we = in_acc && pix_live;
    assign older_we = s1_valid_reg && !s1_reg.drain;

    always_ff @(posedge clk)
    begin
        if (newer_we) newer_mem[in_col_reg] <= pix_in.pixel;
        newer_rd_a_reg <= newer_mem[addr_a];
        newer_rd_b_reg <= newer_mem[addr_b];
    end

    always_ff @(posedge clk)
    begin
        if (older_we) older_mem[s1_reg.addr] <= newer_rd_a_reg;
        older_rd_a_reg <= older_mem[addr_a];
        older_rd_b_reg <= older_mem[addr_b];
    end

    // older store write-back collides with a read of the same address: forward it
    always_ff @(posedge clk)
    begin
        fwd_a_reg    <= older_we && (s1_reg.addr == addr_a);
        fwd_b_reg    <= older_we && (s1_reg.addr == addr_b);
        fwd_data_reg <= newer_rd_a_reg;
    end

    // stage 1
    stage_t s1_next;

    always_comb
    begin
        s1_next.drain   = !pix_live;
        s1_next.emit    = (in_row_reg != '0);
        s1_next.single  = row_is_one;
        s1_next.first   = pix_live ? (in_col_reg == '0) : (out_col_reg == '0);
        s1_next.row_end = row_end;
        s1_next.addr    = pix_live ? in_col_reg : out_col_reg;
        s1_next.row_out = ROW_W'(in_row_reg - ROWCNT_W'(1));
        s1_next.pixel   = pix_in.pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= in_acc && (pix_live || drain_live);
    end

    always_ff @(posedge clk)
    begin
        if (in_acc) s1_reg <= s1_next;
    end

    logic    single_sel;
    pix_t    older_a;
    pix_t    older_b;
    pix_t    top_a;
    pix_t    top_b;
    column_t col_a;
    column_t col_b;
    column_t col_new;
    window_t win_reg;
    window_t win_next;
    window_t tail_win;
    window_t drain_win;
    logic    max_shift;
    logic    max_tail;
    logic    max_drain;

    always_comb
    begin
        single_sel   = s1_valid_reg ? s1_reg.single : row_is_one;
        older_a      = fwd_a_reg ? fwd_data_reg : older_rd_a_reg;
        older_b      = fwd_b_reg ? fwd_data_reg : older_rd_b_reg;
        top_a        = single_sel ? newer_rd_a_reg : older_a;
        top_b        = single_sel ? newer_rd_b_reg : older_b;
        col_a        = '{top: top_a, mid: newer_rd_a_reg, bot: newer_rd_a_reg};
        col_b        = '{top: top_b, mid: newer_rd_b_reg, bot: newer_rd_b_reg};
        col_new      = '{top: top_a, mid: newer_rd_a_reg, bot: s1_reg.pixel};
        if (s1_reg.first)
        begin
            win_next[0] = col_new;
            win_next[1] = col_new;
        end
        else
        begin
            win_next[0] = win_reg[1];
            win_next[1] = win_reg[2];
        end
        win_next[2]  = col_new;
        tail_win[0]  = win_next[1];
        tail_win[1]  = win_next[2];
        tail_win[2]  = win_next[2];
        drain_win[0] = s1_reg.first ? col_a : prev_col_reg;
        drain_win[1] = col_a;
        drain_win[2] = col_b;
        max_shift    = judge(win_next);
        max_tail     = judge(tail_win);
        max_drain    = judge(drain_win);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else if (s1_valid_reg && !s1_reg.drain && s1_reg.emit)
            win_reg <= win_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_ok_reg <= 1'b0;
        else if (newer_we)
            prev_ok_reg <= 1'b0;
        else if ((s1_valid_reg && s1_reg.drain) || (fix_state_reg == FIX_LOAD))
            prev_ok_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if ((s1_valid_reg && s1_reg.drain) || (fix_state_reg == FIX_LOAD))
            prev_col_reg <= col_a;
    end

    // result queue, one entry per item that gives a result
    logic                  s1_push;
    group_t                grp_new;
    group_t                fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]      fifo_cnt_reg;
    logic                  sel_reg;
    group_t                head;
    logic                  out_beat;
    logic                  grp_pop;

    assign s1_push = s1_valid_reg
                     && (s1_reg.drain || (s1_reg.emit && (!s1_reg.first || s1_reg.row_end)));

    always_comb
    begin
        grp_new.row = s1_reg.row_out;
        if (s1_reg.drain)
        begin
            grp_new.col0 = COL_W'(s1_reg.addr);
            grp_new.max0 = max_drain;
            grp_new.max1 = 1'b0;
            grp_new.two  = 1'b0;
        end
        else
        begin
            grp_new.col0 = s1_reg.first ? COL_W'(s1_reg.addr)
                                        : COL_W'(s1_reg.addr - ADDR_W'(1));
            grp_new.max0 = s1_reg.first ? max_tail : max_shift;
            grp_new.max1 = max_tail;
            grp_new.two  = !s1_reg.first && s1_reg.row_end;
        end
    end

    assign pix_in.ready = (fix_state_reg != FIX_READ) && !need_fix
                          && ((fifo_cnt_reg + CNT_W'(s1_push)) < CNT_W'(FIFO_DEPTH));

    assign head           = fifo_mem[rd_ptr_reg];
    assign res_out.valid  = (fifo_cnt_reg != '0);
    assign res_out.col    = head.col0 + COL_W'(sel_reg);
    assign res_out.row    = head.row;
    assign res_out.is_max = sel_reg ? head.max1 : head.max0;
    assign res_out.last   = (sel_reg == head.two);
    assign out_beat       = res_out.valid && res_out.ready;
    assign grp_pop        = out_beat && res_out.last;

    always_ff @(posedge clk)
    begin
        if (s1_push) fifo_mem[wr_ptr_reg] <= grp_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            sel_reg      <= 1'b0;
        end
        else
        begin
            if (s1_push) wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (grp_pop) rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            fifo_cnt_reg <= fifo_cnt_reg + CNT_W'(s1_push) - CNT_W'(grp_pop);
            if (out_beat) sel_reg <= !res_out.last;
        end
    end

endmodule

`default_nettype wire

### design/lm3_checker.sv
`default_nettype none
`include "local_maxima_3x3_detector_core_defines.svh"

module lm3_checker (
    input wire                     clk,
    input wire                     rst_n,
    input wire                     cfg_valid,
    input wire                     cfg_ready,
    input wire                     out_valid,
    input wire                     out_ready,
    input wire [lm3_pkg::COL_W-1:0] out_col,
    input wire [lm3_pkg::ROW_W-1:0] out_row,
    input wire                     out_is_max,
    input wire                     out_last
);
    import lm3_pkg::*;

    `LM3_ASSERT_RESET(a_no_result_in_reset, !out_valid, "result shown during reset")

    `LM3_ASSERT_NOW(a_cfg_never_stalls, cfg_valid, cfg_ready, "config write stalled")

    `LM3_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(out_col) && $stable(out_row) && $stable(out_is_max) && $stable(out_last), "stalled result changed")

    `LM3_ASSERT_NEXT(a_pair_follows, out_valid && out_ready && !out_last, out_valid && out_last && (out_col == $past(out_col) + COL_W'(1)) && (out_row == $past(out_row)), "second result of a row end missing or wrong")

endmodule

bind local_maxima_3x3_detector_core lm3_checker u_lm3_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg.valid),
    .cfg_ready  (cfg.ready),
    .out_valid  (res_out.valid),
    .out_ready  (res_out.ready),
    .out_col    (res_out.col),
    .out_row    (res_out.row),
    .out_is_max (res_out.is_max),
    .out_last   (res_out.last)
);

`default_nettype wire
